// ----- rtl/vmpk_pkg.sv -----
// ----------------------------------------------------------------------------
// vmpk_pkg
// shared widths, defaults and threshold tables for the vu meter core
// ----------------------------------------------------------------------------
`default_nettype none

package vmpk_pkg;

   // fixed field widths
   localparam int LEVEL_W   = 16;
   localparam int MAG_W     = 15;
   localparam int BAR_OUT_W = 20;
   localparam int BAR_IDX_W = 5;
   localparam int THR_W     = 16;
   localparam int THR_DEPTH = 32;

   // parameter defaults
   localparam int NUM_BARS_DEF     = 20;
   localparam int HOLD_UPDATES_DEF = 30;

   // 2^19 / 10 rounded up, exact quotient for 15-bit dividends
   localparam int DIV10_RECIP = 52429;
   localparam int DIV10_SHIFT = 19;

   typedef logic [THR_W-1:0] thr_type;
   typedef thr_type thr_table_type [THR_DEPTH];

   // floor(26214.4 * 10^(-m/5)), level must exceed it to light the bar
   localparam thr_table_type LVL_THR = '{
      16'd26214, 16'd16540, 16'd10436, 16'd6584, 16'd4154, 16'd2621, 16'd1654, 16'd1043,
      16'd658,   16'd415,   16'd262,   16'd165,  16'd104,  16'd65,   16'd41,   16'd26,
      16'd16,    16'd10,    16'd6,     16'd4,    16'd2,    16'd1,    16'd1,    16'd0,
      16'd0,     16'd0,     16'd0,     16'd0,    16'd0,    16'd0,    16'd0,    16'd0
   };

   // floor(33001.97 * 10^(-m/5)), peak at or below it places the marker
   localparam thr_table_type PK_THR = '{
      16'd33001, 16'd20822, 16'd13138, 16'd8289, 16'd5230, 16'd3300, 16'd2082, 16'd1313,
      16'd828,   16'd523,   16'd330,   16'd208,  16'd131,  16'd82,   16'd52,   16'd33,
      16'd20,    16'd13,    16'd8,     16'd5,    16'd3,    16'd2,    16'd1,    16'd0,
      16'd0,     16'd0,     16'd0,     16'd0,    16'd0,    16'd0,    16'd0,    16'd0
   };

endpackage

`default_nettype wire

// ----- rtl/vu_meter_peak_hold_bargraph_core.sv -----
// order: a req transfer loads the input register, and its update then moves to the
// result register, where rsp_valid rises; rsp_stall can hold it in the input register
// throughput: one update per cycle while rsp_stall does not hold the result register,
// set by the combinational channel logic between the input and result registers
// reset: synchronous active high; clears peaks, hold counters, mono mode
// and both valid flags, no clearing pass
// ----------------------------------------------------------------------------
// vu_meter_peak_hold_bargraph_core
// stereo level meter with peak hold and decay, reduced to bar masks
// ----------------------------------------------------------------------------
`default_nettype none

module vu_meter_peak_hold_bargraph_core #(
   parameter int NUM_BARS     = vmpk_pkg::NUM_BARS_DEF,
   parameter int HOLD_UPDATES = vmpk_pkg::HOLD_UPDATES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // update channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [vmpk_pkg::LEVEL_W-1:0] req_level_left,
   input  wire logic signed [vmpk_pkg::LEVEL_W-1:0] req_level_right,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [vmpk_pkg::BAR_OUT_W-1:0]           rsp_bars_left,
   output logic [vmpk_pkg::BAR_IDX_W-1:0]           rsp_peak_bar_left,
   output logic [vmpk_pkg::BAR_OUT_W-1:0]           rsp_bars_right,
   output logic [vmpk_pkg::BAR_IDX_W-1:0]           rsp_peak_bar_right,
   // mono mode register write
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic                                csr_data
);
   import vmpk_pkg::*;

   // input register
   logic                      s1_valid_ff, s1_valid_in;
   logic signed [LEVEL_W-1:0] s1_left_ff, s1_right_ff;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [BAR_OUT_W-1:0]      bars_left_ff, bars_right_ff;
   logic [BAR_IDX_W-1:0]      pbar_left_ff, pbar_right_ff;

   logic                      mono_ff;

   logic                      req_xfer;
   logic                      out_free;
   logic                      advance;

   logic [NUM_BARS-1:0]       ch_bars_left, ch_bars_right;
   logic [BAR_IDX_W-1:0]      ch_marker_left, ch_marker_right;
   logic [BAR_OUT_W-1:0]      bars_left_w, bars_right_w;

   // config port always ready; it is to be written only while idle, which the block does not enforce
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mono_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         mono_ff <= csr_data;
      end
   end

   // result register frees up when empty or its result is being taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture the raw levels on a req transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_left_ff  <= req_level_left;
         s1_right_ff <= req_level_right;
      end
   end

   // channel state moves only when its update reaches the result register;
   // in mono mode the second channel holds its state
   vmpk_channel #(
      .NUM_BARS     (NUM_BARS),
      .HOLD_UPDATES (HOLD_UPDATES)
   ) u_left (
      .clock  (clock),
      .reset  (reset),
      .update (advance),
      .level  (s1_left_ff),
      .bars   (ch_bars_left),
      .marker (ch_marker_left)
   );

   vmpk_channel #(
      .NUM_BARS     (NUM_BARS),
      .HOLD_UPDATES (HOLD_UPDATES)
   ) u_right (
      .clock  (clock),
      .reset  (reset),
      .update (advance && !mono_ff),
      .level  (s1_right_ff),
      .bars   (ch_bars_right),
      .marker (ch_marker_right)
   );

   // fit the bar masks to the output width, unused bits read zero
   for (genvar i = 0; i < BAR_OUT_W; i++) begin : g_out
      if (i < NUM_BARS) begin : g_used
         assign bars_left_w[i]  = ch_bars_left[i];
         assign bars_right_w[i] = ch_bars_right[i];
      end else begin : g_unused
         assign bars_left_w[i]  = 1'b0;
         assign bars_right_w[i] = 1'b0;
      end
   end

   // result register, mono mode blanks the second channel
   always_ff @(posedge clock) begin
      if (advance) begin
         bars_left_ff <= bars_left_w;
         pbar_left_ff <= ch_marker_left;
         if (mono_ff) begin
            bars_right_ff <= '0;
            pbar_right_ff <= BAR_IDX_W'(NUM_BARS);
         end else begin
            bars_right_ff <= bars_right_w;
            pbar_right_ff <= ch_marker_right;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bars_left      = bars_left_ff;
   assign rsp_peak_bar_left  = pbar_left_ff;
   assign rsp_bars_right     = bars_right_ff;
   assign rsp_peak_bar_right = pbar_right_ff;

endmodule

`default_nettype wire

// ----- rtl/vmpk_channel.sv -----
// ----------------------------------------------------------------------------
// vmpk_channel
// one meter channel: magnitude, peak hold and decay, bar mask and marker
// ----------------------------------------------------------------------------
`default_nettype none

module vmpk_channel #(
   parameter int NUM_BARS     = vmpk_pkg::NUM_BARS_DEF,
   parameter int HOLD_UPDATES = vmpk_pkg::HOLD_UPDATES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                update,
   input  wire logic signed [vmpk_pkg::LEVEL_W-1:0] level,
   output logic [NUM_BARS-1:0]                      bars,
   output logic [vmpk_pkg::BAR_IDX_W-1:0]           marker
);
   import vmpk_pkg::*;

   localparam int HOLD_W = $clog2(HOLD_UPDATES + 1);
   localparam int PROD_W = MAG_W + 16;

   logic [MAG_W-1:0]    lvl;
   logic [MAG_W-1:0]    peak_ff, peak_in;
   logic [HOLD_W-1:0]   hold_ff, hold_in;
   logic [MAG_W-1:0]    diff;
   logic [PROD_W-1:0]   prod;
   logic [MAG_W-1:0]    step;
   logic [LEVEL_W-1:0]  neg;
   logic [NUM_BARS-1:0] lit;
   logic [NUM_BARS-1:0] hit;

   // magnitude, most negative code saturates
   assign neg = LEVEL_W'(~level) + LEVEL_W'(1);
   always_comb begin
      if (!level[LEVEL_W-1]) begin
         lvl = level[MAG_W-1:0];
      end else if (neg[LEVEL_W-1]) begin
         lvl = {MAG_W{1'b1}};
      end else begin
         lvl = neg[MAG_W-1:0];
      end
   end

   // decay step (peak - level) / 10 by reciprocal multiply
   assign diff = peak_ff - lvl;
   assign prod = PROD_W'(diff) * PROD_W'(DIV10_RECIP);
   assign step = MAG_W'(prod[PROD_W-1:DIV10_SHIFT]);

   always_comb begin
      peak_in = peak_ff;
      hold_in = hold_ff;
      if (peak_ff < lvl) begin
         peak_in = lvl;
         hold_in = HOLD_W'(HOLD_UPDATES);
      end else if (hold_ff != '0) begin
         hold_in = hold_ff - HOLD_W'(1);
      end else if (peak_ff > lvl) begin
         peak_in = peak_ff - step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
         hold_ff <= '0;
      end else if (update) begin
         peak_ff <= peak_in;
         hold_ff <= hold_in;
      end
   end

   // per-bar threshold compares, table index counts down from the top bar
   for (genvar b = 0; b < NUM_BARS; b++) begin : g_bar
      localparam int M = NUM_BARS - 1 - b;
      assign lit[b] = THR_W'(lvl) > LVL_THR[M];
      assign hit[b] = THR_W'(peak_in) <= PK_THR[M];
   end

   // hit is monotone in b, so its lowest set bit is where it first turns on
   assign bars = lit | (hit & ~(hit << 1));

   always_comb begin
      marker = BAR_IDX_W'(NUM_BARS);
      for (int b = NUM_BARS - 1; b >= 0; b--) begin
         if (hit[b]) begin
            marker = BAR_IDX_W'(b);
         end
      end
   end

endmodule

`default_nettype wire
